FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge, skipped while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rmom_pkg.sv
// ----------------------------------------------------------------------------
// rmom_pkg
// Shared types and constants of the robust outlier-rejecting mean block.
// ----------------------------------------------------------------------------
package rmom_pkg;

  localparam int unsigned DefMaxSamples = 16;
  localparam int unsigned SampleW       = 16;
  localparam int unsigned CountOutW     = 5;
  localparam int unsigned KZ            = 6745;
  localparam int unsigned KMad          = 35000;

  // Input word: one sample of a pixel.
  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last_sample;
  } sample_word_t;

  // Output word: the blend result of one pixel.
  typedef struct packed {
    logic [SampleW-1:0]   blended_value;
    logic [CountOutW-1:0] inlier_count;
    logic                 overflowed;
  } blend_word_t;

  typedef enum logic [2:0] {
    StCollect,
    StSort1,
    StMed,
    StSort2,
    StMad,
    StTest,
    StDiv,
    StOut
  } state_e;

  // Control word from the sequencer to every cell of the chain.
  typedef struct packed {
    logic clear;    // empty the chain
    logic insert;   // insert key into the sorted chain
    logic rotate;   // shift stored samples around the ring
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/rmom_if.sv
// ----------------------------------------------------------------------------
// rmom_if
// Valid/ready channel carrying one word with a generic payload.
// ----------------------------------------------------------------------------
interface rmom_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rmom_cell.sv
// ----------------------------------------------------------------------------
// rmom_cell
// One cell of the sorting chain: holds a ring sample and a sorted key.
// ----------------------------------------------------------------------------
module rmom_cell import rmom_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctrl_t         ctrl_i,
  input  logic [SampleW-1:0] key_i,
  // Neighbor on the left (towards the head of the chain).
  input  logic [SampleW-1:0] left_sort_i,
  input  logic               left_valid_i,
  input  logic               left_moves_i,
  input  logic [SampleW-1:0] ring_i,
  output logic [SampleW-1:0] sort_o,
  output logic               valid_o,
  output logic               moves_o,
  output logic [SampleW-1:0] ring_o
);
  logic [SampleW-1:0] sort_q, sort_d, ring_q;
  logic               valid_q, valid_d;

  // Cell shifts right when the key goes before it or the cell is empty.
  assign moves_o = !valid_q || (sort_q > key_i);

  always_comb begin
    sort_d  = sort_q;
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.insert && moves_o) begin
      valid_d = 1'b1;
      if (left_moves_i) begin
        sort_d = left_sort_i;
        valid_d = left_valid_i;
        if (!left_valid_i) sort_d = key_i;
      end else begin
        sort_d = key_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sort_q <= sort_d;
    if (ctrl_i.rotate) ring_q <= ring_i;
  end

  assign sort_o  = sort_q;
  assign valid_o = valid_q;
  assign ring_o  = ring_q;
endmodule

FILE: hw/rtl/robust_mad_outlier_mean_core.sv
// ----------------------------------------------------------------------------
// robust_mad_outlier_mean_core
// Per-pixel mean of samples after outlier rejection by the modified z-score.
// ----------------------------------------------------------------------------
// Usage: samples of one pixel arrive on in_if, one word each, the last one
// flagged by last_sample. Zero samples are skipped; up to MaxSamples nonzero
// samples are kept in a ring of cells, the rest are dropped and reported in
// overflowed. After the last word the block computes the median by inserting
// each kept sample into a sorted chain of cells (one sample a cycle), then
// the MAD the same way over |x - median|, then one pass of the ring to sum
// the inliers, then a restoring division one quotient bit a cycle.
// The division stops at once when no sample is an inlier. Ordinary samples
// are taken one a cycle. While a pixel is in evaluation in_if is not ready.
// The result sits in an output register until out_if takes it. The next
// pixel is collected meanwhile, and its result waits in the last step of the
// evaluation until the register is free, so a stalled receiver stops the
// input only after one more full pixel. Reset empties the store and clears
// the overflow flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module robust_mad_outlier_mean_core import rmom_pkg::*; #(
  parameter int unsigned MaxSamples = DefMaxSamples
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rmom_if.sink   in_if,
  rmom_if.source out_if
);
  localparam int unsigned CntW = $clog2(MaxSamples + 1);
  localparam int unsigned SumW = SampleW + CntW;

  state_e state_q, state_d;
  logic [CntW-1:0] n_q, n_d, idx_q, idx_d;
  logic            ovf_q, ovf_d;
  logic [SampleW-1:0] first_q, first_d, med_q, med_d, mad_q, mad_d;
  logic [SumW-1:0]    sum_q, sum_d, rem_q, rem_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [SampleW-1:0] quo_q, quo_d;
  logic [4:0]         bit_q, bit_d;
  logic [SampleW-1:0] res_q, res_d;
  logic [CountOutW-1:0] rcnt_q, rcnt_d;
  logic               rovf_q, rovf_d, ovalid_q, ovalid_d;

  logic [SampleW-1:0] smp;
  logic               lst;
  assign smp = in_if.data.sample;
  assign lst = in_if.data.last_sample;

  cell_ctrl_t ctrl;
  logic [SampleW-1:0] key;
  logic [SampleW-1:0] sort_w [MaxSamples];
  logic               valid_w [MaxSamples];
  logic               moves_w [MaxSamples];
  logic [SampleW-1:0] ring_w [MaxSamples];
  logic [SampleW-1:0] head, dev;

  // Head of the ring: the oldest sample leaves cell zero and comes back
  // at the tail, so one full rotation visits every kept sample in order.
  assign head = ring_w[0];
  assign dev  = (head > med_q) ? head - med_q : med_q - head;
  logic collecting, in_fire;
  assign collecting = (state_q == StCollect);
  assign in_if.ready = collecting;
  assign in_fire = in_if.valid && collecting;

  // Ring input: new samples enter at the position of the count, the ring
  // rotates while samples are recycled. Insertion into a ring of n entries
  // is done with a rotate-by-position trick: the chain is a shift line and
  // samples land in the tail; cell i feeds from cell i+1.
  logic keep;
  assign keep = in_fire && (smp != '0) && (n_q < CntW'(MaxSamples));

  for (genvar g = 0; g < MaxSamples; g++) begin : g_cell
    logic [SampleW-1:0] lsort, rin;
    logic               lvalid, lmoves;
    if (g == 0) begin : g_head
      assign lsort = '0;
      assign lvalid = 1'b0;
      assign lmoves = 1'b0;
    end else begin : g_link
      assign lsort = sort_w[g-1];
      assign lvalid = valid_w[g-1];
      assign lmoves = moves_w[g-1];
    end
    // A new sample is written in the cell at the current count; during
    // rotation each cell takes its right neighbor and the last live cell
    // takes the head.
    always_comb begin
      if (collecting) begin
        rin = smp;
      end else if (CntW'(g) + 1'b1 == n_q) begin
        rin = head;
      end else if (g == MaxSamples - 1) begin
        rin = head;
      end else begin
        rin = ring_w[(g + 1) % MaxSamples];
      end
    end
    cell_ctrl_t cc;
    always_comb begin
      cc = ctrl;
      cc.rotate = collecting ? (keep && n_q == CntW'(g)) : ctrl.rotate;
    end
    rmom_cell u_cell (
      .clk_i, .rst_ni, .ctrl_i(cc), .key_i(key),
      .left_sort_i(lsort), .left_valid_i(lvalid), .left_moves_i(lmoves),
      .ring_i(rin), .sort_o(sort_w[g]), .valid_o(valid_w[g]),
      .moves_o(moves_w[g]), .ring_o(ring_w[g])
    );
  end

  // Middle taps of the sorted chain.
  logic [CntW-1:0] hi_i, lo_i;
  logic [SampleW-1:0] mid_v;
  logic [SampleW:0]   mid_s;
  always_comb begin
    hi_i = n_q >> 1;
    lo_i = n_q[0] ? hi_i : hi_i - 1'b1;
    mid_s = {1'b0, sort_w[lo_i[$clog2(MaxSamples > 1 ? MaxSamples : 2)-1:0]]}
          + {1'b0, sort_w[hi_i[$clog2(MaxSamples > 1 ? MaxSamples : 2)-1:0]]};
    mid_v = (n_q == '0) ? '0 : mid_s[SampleW:1];
  end

  logic inl;
  assign inl = (mad_q != '0) && (dev != '0) &&
               (35'(KZ) * 35'(dev) < 35'(KMad) * 35'(mad_q));
  logic [SumW:0] trial;
  assign trial = {rem_q, quo_q[SampleW-1]} - {{(SumW-CntW+1){1'b0}}, cnt_q};

  always_comb begin
    state_d = state_q; n_d = n_q; idx_d = idx_q; ovf_d = ovf_q;
    first_d = first_q; med_d = med_q; mad_d = mad_q; sum_d = sum_q;
    cnt_d = cnt_q; rem_d = rem_q; quo_d = quo_q; bit_d = bit_q;
    res_d = res_q; rcnt_d = rcnt_q; rovf_d = rovf_q;
    ovalid_d = ovalid_q && !out_if.ready;
    case (state_q)
      StCollect: begin
        if (in_fire) begin
          if (keep) begin
            n_d = n_q + 1'b1;
            if (n_q == '0) first_d = smp;
          end else if (smp != '0) begin
            ovf_d = 1'b1;
          end
          if (lst) begin
            state_d = StSort1;
            idx_d = '0;
          end
        end
      end
      StSort1: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == n_q || n_q == '0) state_d = StMed;
      end
      StMed: begin
        med_d = mid_v;
        idx_d = '0;
        state_d = StSort2;
      end
      StSort2: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == n_q || n_q == '0) state_d = StMad;
      end
      StMad: begin
        mad_d = mid_v;
        idx_d = '0; sum_d = '0; cnt_d = '0;
        state_d = StTest;
      end
      StTest: begin
        if (idx_q == n_q) begin
          state_d = StDiv;
          rem_d = '0;
          quo_d = sum_q[SampleW-1:0];
          bit_d = '0;
        end else begin
          idx_d = idx_q + 1'b1;
          if (inl) begin
            sum_d = sum_q + SumW'(head);
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      StDiv: begin
        // Restoring division, one quotient bit a cycle; the sum of at most
        // MaxSamples 16-bit words over their count fits 16 bits, so the
        // upper sum bits seed the remainder.
        if (bit_q == '0 && rem_q == '0) begin
          rem_d = sum_q >> SampleW;
        end
        if (cnt_q == '0) begin
          bit_d = 5'd16;
        end else begin
          if (bit_q == '0) begin
            rem_d = sum_q >> SampleW;
            bit_d = 5'd1;
          end else begin
            if (!trial[SumW]) rem_d = trial[SumW-1:0];
            else rem_d = {rem_q[SumW-2:0], quo_q[SampleW-1]};
            quo_d = {quo_q[SampleW-2:0], !trial[SumW]};
            bit_d = bit_q + 1'b1;
          end
        end
        if (bit_q == 5'd16 || cnt_q == '0) state_d = StOut;
      end
      StOut: begin
        if (!ovalid_d) begin
          res_d = (cnt_q != '0) ? quo_q : ((n_q != '0) ? first_q : '0);
          rcnt_d = (CntW > CountOutW && cnt_q > CntW'(31)) ? '1
                 : CountOutW'(cnt_q);
          rovf_d = ovf_q;
          ovalid_d = 1'b1;
          n_d = '0; ovf_d = 1'b0;
          state_d = StCollect;
        end
      end
      default: state_d = StCollect;
    endcase
  end

  always_comb begin
    ctrl = '0;
    key  = head;
    case (state_q)
      StCollect: ctrl.clear = 1'b1;
      StSort1: begin
        ctrl.insert = (idx_q != n_q);
        ctrl.rotate = (idx_q != n_q);
      end
      StMed: ctrl.clear = 1'b1;
      StSort2: begin
        key = dev;
        ctrl.insert = (idx_q != n_q);
        ctrl.rotate = (idx_q != n_q);
      end
      StTest: ctrl.rotate = (idx_q != n_q);
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StCollect; n_q <= '0; ovf_q <= 1'b0; ovalid_q <= 1'b0;
      idx_q <= '0; bit_q <= '0;
    end else begin
      state_q <= state_d; n_q <= n_d; ovf_q <= ovf_d; ovalid_q <= ovalid_d;
      idx_q <= idx_d; bit_q <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d; med_q <= med_d; mad_q <= mad_d; sum_q <= sum_d;
    cnt_q <= cnt_d; rem_q <= rem_d; quo_q <= quo_d;
    res_q <= res_d; rcnt_q <= rcnt_d; rovf_q <= rovf_d;
  end

  assign out_if.valid = ovalid_q;
  assign out_if.data.blended_value = res_q;
  assign out_if.data.inlier_count = rcnt_q;
  assign out_if.data.overflowed = rovf_q;

  `ASSERT_IMPL(a_cnt_le_n, clk_i, rst_ni, 1'b1, n_q <= CntW'(MaxSamples),
    "kept count above capacity")
  `ASSERT_IMPL(a_no_in_busy, clk_i, rst_ni, state_q != StCollect, !in_if.ready,
    "input ready during evaluation")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_if.valid && !out_if.ready,
    out_if.valid, "result dropped while stalled")
endmodule
